[rtl/stt_pkg.sv]
// Package: shared types, codes and sizes of the sorted timestamp table.
package stt_pkg;

  // Default number of table entries.
  localparam int unsigned CAPACITY = 32;

  // Field widths of one beat.
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned YEAR_W     = 12;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MINUTE_W   = 6;
  localparam int unsigned DUR_H_W    = 8;
  localparam int unsigned DUR_M_W    = 6;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE      = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_PUT,
    S_FIN
  } state_e;

  // Year sits in the top bits so the packed value orders keys lexicographically.
  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } key_t;

  typedef struct packed {
    logic [DUR_H_W-1:0] hours;
    logic [DUR_M_W-1:0] minutes;
  } dur_t;

  typedef struct packed {
    key_t key;
    dur_t dur;
  } entry_t;

  typedef struct packed {
    logic ge;
    logic eq;
  } cmp_res_t;

endpackage

[rtl/stt_in_if.sv]
// Interface: command channel of the sorted timestamp table.
interface stt_in_if;
  logic                            valid;
  logic                            ready;
  logic [stt_pkg::CMD_W-1:0]       cmd;
  logic [stt_pkg::YEAR_W-1:0]      key_year;
  logic [stt_pkg::MONTH_W-1:0]     key_month;
  logic [stt_pkg::DAY_W-1:0]       key_day;
  logic [stt_pkg::HOUR_W-1:0]      key_hour;
  logic [stt_pkg::MINUTE_W-1:0]    key_minute;
  logic [stt_pkg::DUR_H_W-1:0]     dur_hours;
  logic [stt_pkg::DUR_M_W-1:0]     dur_minutes;

  modport source (
    output valid, cmd, key_year, key_month, key_day, key_hour, key_minute,
           dur_hours, dur_minutes,
    input  ready
  );

  modport sink (
    input  valid, cmd, key_year, key_month, key_day, key_hour, key_minute,
           dur_hours, dur_minutes,
    output ready
  );
endinterface

[rtl/stt_out_if.sv]
// Interface: result channel of the sorted timestamp table.
interface stt_out_if;
  logic                          valid;
  logic                          ready;
  logic [stt_pkg::STATUS_W-1:0]  status;
  logic                          found;
  logic [stt_pkg::DUR_H_W-1:0]   removed_dur_hours;
  logic [stt_pkg::DUR_M_W-1:0]   removed_dur_minutes;
  logic [stt_pkg::COUNT_W-1:0]   entry_count;

  modport source (
    output valid, status, found, removed_dur_hours, removed_dur_minutes, entry_count,
    input  ready
  );

  modport sink (
    input  valid, status, found, removed_dur_hours, removed_dur_minutes, entry_count,
    output ready
  );
endinterface

[rtl/sorted_timestamp_table.sv]
// Top level: sorted timestamp table with a sequenced walk over one entry memory.
//
//   channel | direction | beat contents
//   --------+-----------+-----------------------------------------------------
//   in_i    | sink      | cmd, key_year..key_minute, dur_hours, dur_minutes
//   out_o   | source    | status, found, removed_dur_hours/minutes, entry_count
//
// The time one command takes grows with N, the number of entries held, and is
// set by the single read port of the entry memory: the walk reads one entry per
// cycle up to the insert or match position, and the shift reads one entry per
// cycle between there and the end while writing the previous one a place up or
// down, so together they read no held entry more than twice.
// Reset clears the count and the control state; entry contents stay undefined.
// The block takes no new beat until the result of the current one is loaded
// into the output register, which waits there while the sink stalls.
module sorted_timestamp_table #(
  parameter int unsigned CAPACITY = stt_pkg::CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stt_in_if.sink      in_i,
  stt_out_if.source   out_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);
  localparam logic [CW-1:0] OneC = CW'(1);

  stt_pkg::state_e state_q, state_d;

  // Latched command beat.
  stt_pkg::cmd_e   cmd_q;
  stt_pkg::key_t   key_q;
  stt_pkg::dur_t   dur_q;

  // Table occupancy and walk pointers.
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   scan_q;
  logic [CW-1:0]   cmp_idx_q;
  logic [CW-1:0]   pos_q;
  logic [CW-1:0]   n_q;
  logic [CW-1:0]   src_q;
  logic [IW-1:0]   wr_addr_q;
  logic            rd_vld_q;

  // Result of the current command.
  logic            found_q;
  stt_pkg::status_e status_q;
  stt_pkg::dur_t   rem_q;

  // Output register.
  logic            out_vld_q;
  stt_pkg::status_e out_status_q;
  logic            out_found_q;
  stt_pkg::dur_t   out_rem_q;
  logic [stt_pkg::COUNT_W-1:0] out_count_q;

  // Memory and comparator connections.
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  stt_pkg::entry_t mem_wdata;
  logic [IW-1:0]   mem_raddr;
  stt_pkg::entry_t mem_rdata;
  stt_pkg::cmp_res_t cmp_res;

  logic            in_acc;
  logic            scan_hit;
  logic            scan_end;
  logic            present;
  logic [CW-1:0]   hit_pos;
  logic            full;
  logic            move_done;
  logic            out_free;
  logic            scan_issue;
  logic            move_issue;
  logic [CW-1:0]   src_up;
  logic [CW-1:0]   src_dn;
  logic            is_ins;

  stt_mem #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  stt_cmp u_cmp (
    .entry_key_i (mem_rdata.key),
    .probe_key_i (key_q),
    .res_o       (cmp_res)
  );

  assign in_acc = in_i.valid && in_i.ready;

  // The table is sorted, so the first entry not below the probe key is both
  // the insert position and, when equal, the first match.
  assign scan_hit = rd_vld_q && cmp_res.ge;
  assign scan_end = scan_hit || (scan_q == count_q);
  assign present  = scan_hit && cmp_res.eq;
  assign hit_pos  = scan_hit ? cmp_idx_q : count_q;
  assign full     = (count_q == CapC);

  // The shift is over once no moves remain and the last read has been written.
  assign move_done = (n_q == '0) && !rd_vld_q;
  assign out_free  = !out_vld_q || out_o.ready;
  assign is_ins    = (cmd_q == stt_pkg::CMD_INSERT);

  assign scan_issue = (state_q == stt_pkg::S_SCAN) && !scan_end;
  assign move_issue = (state_q == stt_pkg::S_MOVE) && (n_q != '0);

  assign src_up = src_q + OneC;
  assign src_dn = src_q - OneC;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stt_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = stt_pkg::S_SCAN;
        end
      end
      stt_pkg::S_SCAN: begin
        if (scan_end) begin
          case (cmd_q)
            stt_pkg::CMD_INSERT: begin
              if (full) begin
                state_d = stt_pkg::S_FIN;
              end else if (hit_pos == count_q) begin
                state_d = stt_pkg::S_PUT;
              end else begin
                state_d = stt_pkg::S_MOVE;
              end
            end
            stt_pkg::CMD_DELETE: begin
              state_d = present ? stt_pkg::S_MOVE : stt_pkg::S_FIN;
            end
            default: begin
              state_d = stt_pkg::S_FIN;
            end
          endcase
        end
      end
      stt_pkg::S_MOVE: begin
        if (move_done) begin
          state_d = is_ins ? stt_pkg::S_PUT : stt_pkg::S_FIN;
        end
      end
      stt_pkg::S_PUT: begin
        state_d = stt_pkg::S_FIN;
      end
      stt_pkg::S_FIN: begin
        if (out_free) begin
          state_d = stt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = stt_pkg::S_IDLE;
      end
    endcase
  end

  // Memory control and handshake outputs.
  always_comb begin
    in_i.ready = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = wr_addr_q;
    mem_wdata  = mem_rdata;
    mem_raddr  = scan_q[IW-1:0];
    unique case (state_q)
      stt_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
      end
      stt_pkg::S_SCAN: begin
        mem_raddr = scan_q[IW-1:0];
      end
      stt_pkg::S_MOVE: begin
        // Each read entry is written one place over in the following cycle.
        mem_raddr = src_q[IW-1:0];
        mem_we    = rd_vld_q;
      end
      stt_pkg::S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[IW-1:0];
        mem_wdata = '{key: key_q, dur: dur_q};
      end
      stt_pkg::S_FIN: begin
        mem_we = 1'b0;
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= stt_pkg::S_IDLE;
      count_q   <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= scan_issue || move_issue;
      if (state_q == stt_pkg::S_PUT) begin
        count_q <= count_q + OneC;
      end else if ((state_q == stt_pkg::S_MOVE) && move_done && !is_ins) begin
        count_q <= count_q - OneC;
      end
      if ((state_q == stt_pkg::S_FIN) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q    <= stt_pkg::cmd_e'(in_i.cmd);
      key_q    <= '{year: in_i.key_year, month: in_i.key_month, day: in_i.key_day,
                    hour: in_i.key_hour, minute: in_i.key_minute};
      dur_q    <= '{hours: in_i.dur_hours, minutes: in_i.dur_minutes};
      scan_q   <= '0;
      found_q  <= 1'b0;
      status_q <= stt_pkg::STS_DONE;
      rem_q    <= '0;
    end

    if (scan_issue) begin
      scan_q    <= scan_q + OneC;
      cmp_idx_q <= scan_q;
    end

    if ((state_q == stt_pkg::S_SCAN) && scan_end) begin
      pos_q <= hit_pos;
      case (cmd_q)
        stt_pkg::CMD_INSERT: begin
          found_q  <= present;
          status_q <= full ? stt_pkg::STS_FULL : stt_pkg::STS_DONE;
          n_q      <= count_q - hit_pos;
          src_q    <= count_q - OneC;
        end
        stt_pkg::CMD_DELETE: begin
          found_q <= present;
          if (present) begin
            rem_q <= mem_rdata.dur;
            n_q   <= count_q - hit_pos - OneC;
            src_q <= hit_pos + OneC;
          end else begin
            status_q <= stt_pkg::STS_NOT_FOUND;
          end
        end
        stt_pkg::CMD_LOOKUP: begin
          found_q  <= present;
          status_q <= present ? stt_pkg::STS_DONE : stt_pkg::STS_NOT_FOUND;
        end
        default: begin
          found_q <= 1'b0;
        end
      endcase
    end

    if (move_issue) begin
      n_q       <= n_q - OneC;
      src_q     <= is_ins ? src_dn : src_up;
      wr_addr_q <= is_ins ? src_up[IW-1:0] : src_dn[IW-1:0];
    end

    if ((state_q == stt_pkg::S_FIN) && out_free) begin
      out_status_q <= status_q;
      out_found_q  <= found_q;
      out_rem_q    <= rem_q;
      out_count_q  <= stt_pkg::COUNT_W'(count_q);
    end
  end

  assign out_o.valid               = out_vld_q;
  assign out_o.status              = out_status_q;
  assign out_o.found               = out_found_q;
  assign out_o.removed_dur_hours   = out_rem_q.hours;
  assign out_o.removed_dur_minutes = out_rem_q.minutes;
  assign out_o.entry_count         = out_count_q;

endmodule

[rtl/stt_mem.sv]
// Module: entry storage, one write port and one registered read port.
module stt_mem #(
  parameter int unsigned DEPTH = stt_pkg::CAPACITY,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  stt_pkg::entry_t wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output stt_pkg::entry_t rdata_o
);

  stt_pkg::entry_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/stt_cmp.sv]
// Module: shared key comparator used by the table walk.
module stt_cmp (
  input  stt_pkg::key_t     entry_key_i,
  input  stt_pkg::key_t     probe_key_i,
  output stt_pkg::cmp_res_t res_o
);

  // Keys are raw packed numbers, so one magnitude compare orders them.
  assign res_o.ge = (entry_key_i >= probe_key_i);
  assign res_o.eq = (entry_key_i == probe_key_i);

endmodule

[rtl/stt_chk.sv]
// Checker: port-level assertions for the sorted timestamp table, with its bind.
module stt_chk #(
  parameter int unsigned CAPACITY = stt_pkg::CAPACITY
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [stt_pkg::STATUS_W-1:0]  status_i,
  input logic                          found_i,
  input logic [stt_pkg::DUR_H_W-1:0]   rem_hours_i,
  input logic [stt_pkg::DUR_M_W-1:0]   rem_minutes_i,
  input logic [stt_pkg::COUNT_W-1:0]   entry_count_i
);

  // A pending result beat stays until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // One command is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command accepted while another is in progress");

  // The count never exceeds the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (32'(entry_count_i) <= CAPACITY))
    else $error("entry count beyond capacity");

  // A returned duration only comes from a successful delete.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((rem_hours_i != '0) || (rem_minutes_i != '0))
      |-> (status_i == stt_pkg::STS_DONE) && found_i)
    else $error("removed duration without a successful delete");

  // A miss never reports the key as found.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == stt_pkg::STS_NOT_FOUND) |-> !found_i)
    else $error("not found status with found set");

endmodule

bind sorted_timestamp_table stt_chk #(
  .CAPACITY (CAPACITY)
) u_stt_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .found_i       (out_o.found),
  .rem_hours_i   (out_o.removed_dur_hours),
  .rem_minutes_i (out_o.removed_dur_minutes),
  .entry_count_i (out_o.entry_count)
);
